[sv/ils_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed list store package
// Shared types, codes and sizes for the list cells and the top level.
// ----------------------------------------------------------------------------
package ils_pkg;

   // Default sizes of the store
   localparam int ILS_CAPACITY   = 16;
   localparam int ILS_VALUE_BITS = 32;

   // Fixed field widths on the ports
   localparam int POS_BITS       = 5;
   localparam int ITEM_BITS      = 32;
   localparam int STATUS_BITS    = 2;
   localparam int COUNT_OUT_BITS = 5;
   localparam int REQ_TDATA_BITS = 40;
   localparam int RSP_TDATA_BITS = 40;

   // Operation codes
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic                insert_en;
      logic                remove_en;
      logic [POS_BITS-1:0] position;
   } cell_cmd_type;

   // Flags returned by every cell
   typedef struct packed {
      logic sel;
      logic hit;
   } cell_status_type;

endpackage

[sv/ils_cell.sv]
// ----------------------------------------------------------------------------
// Indexed list store cell
// Holds one list entry; shifts from a neighbour on insert or remove and
// flags a position match or a value match for the current word.
// ----------------------------------------------------------------------------
module ils_cell #(
   parameter int INDEX      = 0,
   parameter int VALUE_BITS = ils_pkg::ILS_VALUE_BITS,
   parameter int CMP_BITS   = ils_pkg::POS_BITS
) (
   input  logic                     clock,
   input  ils_pkg::cell_cmd_type    cmd,
   input  logic [CMP_BITS-1:0]      count_ext,
   input  logic [VALUE_BITS-1:0]    key_value,
   input  logic [VALUE_BITS-1:0]    left_value,
   input  logic [VALUE_BITS-1:0]    right_value,
   output logic [VALUE_BITS-1:0]    cell_value,
   output ils_pkg::cell_status_type cell_status
);

   localparam logic [CMP_BITS-1:0] MY_INDEX = CMP_BITS'(INDEX);

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;
   logic [CMP_BITS-1:0]   pos_ext;
   logic                  occupied;

   assign pos_ext  = CMP_BITS'(cmd.position);
   assign occupied = MY_INDEX < count_ext;

   // Pick the next entry: load, take from a neighbour or hold
   always_comb begin
      value_in = value_ff;
      if (cmd.insert_en) begin
         if (MY_INDEX == pos_ext) begin
            value_in = key_value;
         end else if (MY_INDEX > pos_ext) begin
            value_in = left_value;
         end
      end else if (cmd.remove_en) begin
         if (MY_INDEX >= pos_ext) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // Report position and value matches on held entries only
   assign cell_status.sel = occupied && (MY_INDEX == pos_ext);
   assign cell_status.hit = occupied && (value_ff == key_value);
   assign cell_value      = value_ff;

endmodule

[sv/indexed_list_store_top.sv]
// ----------------------------------------------------------------------------
// Indexed list store top level
// Bounded ordered list of handles with insert, remove, read and search.
// ----------------------------------------------------------------------------
// The store takes one request word per clock while each response is taken
// as it appears, and returns one response word in the cycle after
// acceptance; a new request is taken while a response is still waiting as
// long as that response leaves in the same cycle. The list lives in a row
// of CAPACITY cells: an insert shifts the cells behind the position one
// place back, a remove shifts them one place forward, and a search compares
// every held cell in the same cycle. No clearing pass is needed after reset.
module indexed_list_store_top #(
   parameter int CAPACITY   = ils_pkg::ILS_CAPACITY,
   parameter int VALUE_BITS = ils_pkg::ILS_VALUE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: opcode[1:0], position[6:2], item_value[38:7], zero[39]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ils_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // rsp_tdata: status[1:0], found_value[33:2], entry_count[38:34], zero[39]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ils_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int CMP_BITS = (CNT_BITS > ils_pkg::POS_BITS) ? CNT_BITS : ils_pkg::POS_BITS;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CAPACITY);

   // Request fields
   ils_pkg::op_type                 req_opcode;
   logic [ils_pkg::POS_BITS-1:0]    req_position;
   logic [ils_pkg::ITEM_BITS-1:0]   req_item_value;
   logic [VALUE_BITS+ils_pkg::ITEM_BITS-1:0] item_wide;
   logic [VALUE_BITS-1:0]           key_value;

   // Control state
   logic                            accept;
   logic [CNT_BITS-1:0]             count_ff;
   logic [CNT_BITS-1:0]             count_in;
   logic [CMP_BITS-1:0]             count_ext;
   logic [CMP_BITS-1:0]             pos_ext;

   // Row of cells
   ils_pkg::cell_cmd_type           cmd;
   logic [VALUE_BITS-1:0]           cell_value  [CAPACITY];
   ils_pkg::cell_status_type        cell_status [CAPACITY];
   logic [CAPACITY-1:0]             sel_vec;
   logic [CAPACITY-1:0]             hit_vec;
   logic [VALUE_BITS-1:0]           read_value;

   // Result decode
   logic                            insert_ok;
   logic                            remove_ok;
   ils_pkg::status_type             status_in;
   logic [VALUE_BITS-1:0]           found_in;
   logic [VALUE_BITS+ils_pkg::ITEM_BITS-1:0] found_wide;
   logic [CNT_BITS+ils_pkg::COUNT_OUT_BITS-1:0] count_wide;

   // Response register
   logic                            rsp_valid_ff;
   ils_pkg::status_type             rsp_status_ff;
   logic [ils_pkg::ITEM_BITS-1:0]   rsp_found_ff;
   logic [ils_pkg::COUNT_OUT_BITS-1:0] rsp_count_ff;

   // Unpack the request word
   assign req_opcode     = ils_pkg::op_type'(req_tdata[1:0]);
   assign req_position   = req_tdata[6:2];
   assign req_item_value = req_tdata[38:7];
   assign item_wide      = {{VALUE_BITS{1'b0}}, req_item_value};
   assign key_value      = item_wide[VALUE_BITS-1:0];

   // Take a request while the response slot is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign count_ext = CMP_BITS'(count_ff);
   assign pos_ext   = CMP_BITS'(req_position);

   // Validate the operation against the current count
   assign insert_ok = (req_opcode == ils_pkg::OP_INSERT) && (pos_ext <= count_ext)
                      && (count_ff != FULL_COUNT);
   assign remove_ok = (req_opcode == ils_pkg::OP_REMOVE) && (pos_ext < count_ext);

   assign cmd.insert_en = accept && insert_ok;
   assign cmd.remove_en = accept && remove_ok;
   assign cmd.position  = req_position;

   // Build the row of cells
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [VALUE_BITS-1:0] left_value;
      logic [VALUE_BITS-1:0] right_value;

      if (k == 0) begin : g_first
         assign left_value = key_value;
      end else begin : g_inner_left
         assign left_value = cell_value[k-1];
      end

      if (k == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[k];
      end else begin : g_inner_right
         assign right_value = cell_value[k+1];
      end

      ils_cell #(
         .INDEX      (k),
         .VALUE_BITS (VALUE_BITS),
         .CMP_BITS   (CMP_BITS)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count_ext   (count_ext),
         .key_value   (key_value),
         .left_value  (left_value),
         .right_value (right_value),
         .cell_value  (cell_value[k]),
         .cell_status (cell_status[k])
      );

      assign sel_vec[k] = cell_status[k].sel;
      assign hit_vec[k] = cell_status[k].hit;
   end

   // Gather the entry at the read position
   always_comb begin
      read_value = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         read_value = read_value | (cell_value[k] & {VALUE_BITS{sel_vec[k]}});
      end
   end

   // Decide status, found value and next count
   always_comb begin
      status_in = ils_pkg::ST_RANGE;
      found_in  = '0;
      count_in  = count_ff;
      unique case (req_opcode)
         ils_pkg::OP_INSERT: begin
            if (pos_ext > count_ext) begin
               status_in = ils_pkg::ST_RANGE;
            end else if (count_ff == FULL_COUNT) begin
               status_in = ils_pkg::ST_FULL;
            end else begin
               status_in = ils_pkg::ST_OK;
               count_in  = count_ff + CNT_BITS'(1);
            end
         end
         ils_pkg::OP_REMOVE: begin
            if (remove_ok) begin
               status_in = ils_pkg::ST_OK;
               count_in  = count_ff - CNT_BITS'(1);
            end
         end
         ils_pkg::OP_READ: begin
            if (pos_ext < count_ext) begin
               status_in = ils_pkg::ST_OK;
               found_in  = read_value;
            end
         end
         ils_pkg::OP_SEARCH: begin
            // A hit returns the key itself, as it equals the matched entry
            if (|hit_vec) begin
               status_in = ils_pkg::ST_OK;
               found_in  = key_value;
            end
         end
         default: begin
            status_in = ils_pkg::ST_RANGE;
         end
      endcase
   end

   assign found_wide = {{ils_pkg::ITEM_BITS{1'b0}}, found_in};
   assign count_wide = {{ils_pkg::COUNT_OUT_BITS{1'b0}}, count_in};

   // Advance the count on accepted words
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status_in;
         rsp_found_ff  <= found_wide[ils_pkg::ITEM_BITS-1:0];
         rsp_count_ff  <= count_wide[ils_pkg::COUNT_OUT_BITS-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_found_ff, rsp_status_ff};

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_single_sel: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel_vec))
      else $error("more than one cell selected");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert_en |=> count_ff == $past(count_ff) + CNT_BITS'(1))
      else $error("insert did not grow the list");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ils_pkg::ST_OK) |-> rsp_found_ff == '0)
      else $error("failed response carries a value");

endmodule
